// ----- sv/pfsp_pkg.sv -----
// Package for the prime step-up block: controller commands, status and states.
// Used by pfsp_ctrl, pfsp_dp and prime_from_smaller_prime_top.
package pfsp_pkg;
	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_DIV   = 9'b000000010,
		S_CAND  = 9'b000000100,
		S_CHECK = 9'b000001000,
		S_EXP1  = 9'b000010000,
		S_TEST1 = 9'b000100000,
		S_EXP2  = 9'b001000000,
		S_TEST2 = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	typedef struct packed {
		logic load;      // capture request, start division
		logic div_step;  // one restoring division step
		logic cand;      // form candidate p = k*q+1
		logic exp_start; // load exponentiation with exponent
		logic exp_sel;   // 0: p-1, 1: k
		logic exp_step;  // advance the square-and-multiply engine
		logic next_k;    // k += 2
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic bad_q;
		logic over;      // p > limit
		logic exp_done;
		logic exp_one;   // result == 1
	} stat_t;
endpackage

// ----- sv/pfsp_dp.sv -----
// Datapath for the prime step-up block: divider, candidate and modular exponent.
// Depends on pfsp_pkg for command and status types.
module pfsp_dp #(
	parameter int FRAC_W = 16,
	parameter int TW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pfsp_pkg::cmd_t       cmd,
	output pfsp_pkg::stat_t      stat,
	input  logic [5:0]           t_cfg,
	input  logic [15:0]          small_prime,
	input  logic [FRAC_W-1:0]    random_fraction,
	output logic [31:0]          p_out
);
	localparam int NW = FRAC_W + 1 + TW;     // numerator width
	localparam int CW = $clog2(NW + 1);
	localparam int TCAP = (TW < 32) ? TW : 32;

	logic [15:0]       q_q;
	logic [NW-1:0]     num_q;
	logic [NW:0]       rem_q;
	logic [CW-1:0]     dcnt_q;
	logic [33:0]       k_q;
	logic [33:0]       p_q;
	logic [32:0]       limit_q;
	logic [33:0]       e_q;
	logic [31:0]       acc_q;
	logic [31:0]       base_q;
	logic              ephase_q;
	logic [5:0]        mcnt_q;
	logic [33:0]       mr_q;
	logic [31:0]       mb_q;

	logic [5:0]        t_sat;
	logic [NW:0]       rem_sh;
	logic [NW:0]       den_ext;
	logic [49:0]       kq;
	logic [31:0]       ma;
	logic [33:0]       mr2;
	logic [33:0]       mr2m;
	logic [33:0]       mra;
	logic [33:0]       mrn;
	logic              mm_idle;
	logic              mm_start;
	logic              mm_run;
	logic              mm_last;
	logic              ph_skip;

	always_comb begin
		t_sat = t_cfg;
		if (t_sat < 6'd1) t_sat = 6'd1;
		if (t_sat > 6'(TCAP)) t_sat = 6'(TCAP);
	end

	assign rem_sh  = {rem_q[NW-1:0], num_q[NW-1]};
	assign den_ext = (NW+1)'({q_q, {FRAC_W{1'b0}}});
	assign kq      = k_q * q_q;

	// shift-and-add modular multiply, one multiplier bit per cycle
	assign ma   = ephase_q ? acc_q : base_q;
	assign mr2  = {mr_q[32:0], 1'b0};
	assign mr2m = (mr2 >= p_q) ? mr2 - p_q : mr2;
	assign mra  = mr2m + (mb_q[31] ? {2'b00, ma} : 34'd0);
	assign mrn  = (mra >= p_q) ? mra - p_q : mra;

	assign mm_idle  = (mcnt_q == '0);
	assign mm_start = cmd.exp_step && mm_idle &&
		((ephase_q && e_q[0]) || (!ephase_q && e_q[33:1] != '0));
	assign ph_skip  = cmd.exp_step && mm_idle &&
		((ephase_q && !e_q[0] && e_q != '0) || (!ephase_q && e_q[33:1] == '0));
	assign mm_run   = cmd.exp_step && !mm_idle;
	assign mm_last  = mm_run && (mcnt_q == 6'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q   <= '0;
			ephase_q <= 1'b0;
			mcnt_q   <= '0;
		end else begin
			if (cmd.load) dcnt_q <= CW'(NW);
			else if (cmd.div_step && dcnt_q != '0) dcnt_q <= dcnt_q - 1'b1;
			if (cmd.exp_start) begin
				ephase_q <= 1'b1;
				mcnt_q   <= '0;
			end else begin
				if (mm_start) mcnt_q <= 6'd32;
				else if (mm_run) mcnt_q <= mcnt_q - 6'd1;
				if (ph_skip || mm_last) ephase_q <= ~ephase_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			q_q     <= small_prime;
			num_q   <= NW'({1'b1, random_fraction}) << (t_sat - 6'd1);
			rem_q   <= '0;
			limit_q <= 33'd1 << t_sat;
		end else if (cmd.div_step && dcnt_q != '0) begin
			if (rem_sh >= den_ext) begin
				rem_q <= rem_sh - den_ext;
				num_q <= {num_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				num_q <= {num_q[NW-2:0], 1'b0};
			end
		end
		if (cmd.div_step && dcnt_q == '0) begin
			// quotient fits in 34 bits when q >= 2
			k_q <= 34'(num_q) + {33'd0, num_q[0]};
		end else if (cmd.next_k) begin
			k_q <= k_q + 34'd2;
		end
		if (cmd.cand) p_q <= 34'(kq) + 34'd1;
		if (cmd.exp_start) begin
			e_q    <= cmd.exp_sel ? k_q : p_q - 34'd1;
			acc_q  <= 32'd1;
			base_q <= (p_q <= 34'd2) ? 32'd0 : 32'd2;
		end else begin
			if (mm_start) begin
				mr_q <= '0;
				mb_q <= base_q;
			end else if (mm_run) begin
				mr_q <= mrn;
				mb_q <= {mb_q[30:0], 1'b0};
			end
			if (mm_last) begin
				if (ephase_q) acc_q <= mrn[31:0];
				else base_q <= mrn[31:0];
			end
			if (!ephase_q && (mm_last || ph_skip)) e_q <= e_q >> 1;
		end
	end

	assign stat.div_done = (dcnt_q == '0);
	assign stat.bad_q    = (q_q < 16'd2);
	assign stat.over     = ({16'd0, kq} + 66'd1) > {33'd0, limit_q};
	assign stat.exp_done = (e_q == '0) && ephase_q && mm_idle;
	assign stat.exp_one  = (acc_q == 32'd1);
	assign p_out = p_q[31:0];
endmodule

// ----- sv/pfsp_ctrl.sv -----
// Controller for the prime step-up block: sequences division, search and tests.
// Depends on pfsp_pkg for states, commands and status.
module pfsp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            found,
	input  pfsp_pkg::stat_t stat,
	output pfsp_pkg::cmd_t  cmd
);
	pfsp_pkg::state_t state_q, state_d;
	logic found_q, found_d;

	assign in_stall  = (state_q != pfsp_pkg::S_IDLE);
	assign out_valid = (state_q == pfsp_pkg::S_DONE);
	assign found     = found_q;

	always_comb begin
		state_d = state_q;
		found_d = found_q;
		cmd     = '0;
		unique case (state_q)
			pfsp_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					found_d  = 1'b0;
					state_d  = pfsp_pkg::S_DIV;
				end
			end
			pfsp_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.bad_q) state_d = pfsp_pkg::S_DONE;
				else if (stat.div_done) state_d = pfsp_pkg::S_CAND;
			end
			pfsp_pkg::S_CAND: begin
				cmd.cand = 1'b1;
				state_d  = stat.over ? pfsp_pkg::S_DONE : pfsp_pkg::S_CHECK;
			end
			pfsp_pkg::S_CHECK: begin
				cmd.exp_start = 1'b1;
				state_d       = pfsp_pkg::S_EXP1;
			end
			pfsp_pkg::S_EXP1: begin
				cmd.exp_step = 1'b1;
				if (stat.exp_done) begin
					cmd.exp_step = 1'b0;
					state_d      = pfsp_pkg::S_TEST1;
				end
			end
			pfsp_pkg::S_TEST1: begin
				if (stat.exp_one) begin
					cmd.exp_start = 1'b1;
					cmd.exp_sel   = 1'b1;
					state_d       = pfsp_pkg::S_EXP2;
				end else begin
					cmd.next_k = 1'b1;
					state_d    = pfsp_pkg::S_CAND;
				end
			end
			pfsp_pkg::S_EXP2: begin
				cmd.exp_step = 1'b1;
				if (stat.exp_done) begin
					cmd.exp_step = 1'b0;
					state_d      = pfsp_pkg::S_TEST2;
				end
			end
			pfsp_pkg::S_TEST2: begin
				if (!stat.exp_one) begin
					found_d = 1'b1;
					state_d = pfsp_pkg::S_DONE;
				end else begin
					cmd.next_k = 1'b1;
					state_d    = pfsp_pkg::S_CAND;
				end
			end
			pfsp_pkg::S_DONE: begin
				if (!out_stall) state_d = pfsp_pkg::S_IDLE;
			end
			default: state_d = pfsp_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfsp_pkg::S_IDLE;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			found_q <= found_d;
		end
	end

	a_accept_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == pfsp_pkg::S_IDLE) else $error("load outside idle");
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found)) else $error("result lost");
endmodule

// ----- sv/prime_from_smaller_prime_top.sv -----
// Prime step-up block: top level joining controller and datapath.
// Depends on pfsp_pkg, pfsp_ctrl and pfsp_dp.
//
// Takes one request (small_prime, random_fraction) at a time. A restoring
// division forms the first k; each candidate is then formed, checked against
// the limit and tested with one or two modular exponentiations. Every modular
// multiply is a 32-step shift-and-add reduction, and an L-bit exponent needs
// L-1 squarings and one multiply per set bit. The number of candidates
// searched sets the time per request. bit_length is saturated to
// [1, min(MAX_BIT_LENGTH, 32)]; the user must write it only while idle, as
// the block itself does not enforce this. The result holds until taken.
module prime_from_smaller_prime_top #(
	parameter int MAX_BIT_LENGTH = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [5:0]               cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [15:0]              small_prime,
	input  logic [FRACTION_BITS-1:0] random_fraction,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [31:0]              prime_value,
	output logic                     found
);
	pfsp_pkg::cmd_t  cmd;
	pfsp_pkg::stat_t stat;
	logic [5:0]  bit_length_q;
	logic [31:0] p_out;
	logic        found_i;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bit_length_q <= 6'd16;
		else if (cfg_valid && cfg_ready) bit_length_q <= cfg_data;
	end

	pfsp_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.found(found_i), .stat, .cmd
	);

	pfsp_dp #(.FRAC_W(FRACTION_BITS), .TW(MAX_BIT_LENGTH)) u_dp (
		.clk, .arst_n, .cmd, .stat, .t_cfg(bit_length_q),
		.small_prime, .random_fraction, .p_out
	);

	assign found       = found_i;
	assign prime_value = found_i ? p_out : 32'd0;
endmodule
